FILE: rtl/sfpr_pkg.sv
package sfpr_pkg;

  localparam int unsigned STORE_DEPTH = 32;
  localparam int unsigned STORE_AW    = 5;
  localparam int unsigned CRC_FIRST   = 4;
  localparam int unsigned TYPE_AT     = 10;
  localparam int unsigned TARGET_AT   = 11;
  localparam int unsigned CRC_LEN     = 2;
  localparam int unsigned MAX_OUT     = 64;

  localparam logic [2:0] REG_SYNC   = 3'd0;
  localparam logic [2:0] REG_SEED   = 3'd1;
  localparam logic [2:0] REG_BE     = 3'd2;
  localparam logic [2:0] REG_T_CMD  = 3'd3;
  localparam logic [2:0] REG_T_LRT  = 3'd4;
  localparam logic [2:0] REG_T_STOP = 3'd5;
  localparam logic [2:0] REG_T_LOSS = 3'd6;
  localparam logic [2:0] REG_T_GO   = 3'd7;

  localparam logic [1:0] EV_NONE = 2'd0;
  localparam logic [1:0] EV_TYPE = 2'd1;
  localparam logic [1:0] EV_CRC  = 2'd2;
  localparam logic [1:0] EV_ACC  = 2'd3;

  localparam logic [2:0] KIND_CMD     = 3'd0;
  localparam logic [2:0] KIND_UNKNOWN = 3'd5;

  // One status transfer on the result channel
  typedef struct packed {
    logic [1:0]  event_res;
    logic [2:0]  kind;
    logic [31:0] ts_coarse;
    logic [15:0] ts_fine;
    logic [7:0]  dest_addr;
    logic        has_payload;
    logic [7:0]  payload_byte;
    logic        last;
    logic [31:0] accepted_count;
    logic [31:0] crc_error_count;
    logic [31:0] type_error_count;
  } sfpr_result_t;

  // Controller -> datapath
  typedef struct packed {
    logic take;      // consume input byte (hunt or store)
    logic crc_step;  // fold one stored byte into CRC
    logic crc_init;
    logic finish;    // compute verdict / update totals
    logic emit_load; // latch result fields
    logic pay_next;  // advance payload index
  } sfpr_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic in_packet;  // byte just taken went into a packet body
    logic hdr_bad;    // header done, unknown type
    logic need_crc;   // full length reached
    logic crc_done;
    logic stream;     // accepted command, payload will follow
    logic pay_last;
  } sfpr_stat_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      r = r[15] ? ((r << 1) ^ 16'h1021) : (r << 1);
    end
    return r;
  endfunction

endpackage

FILE: rtl/sfpr_stream_if.sv
interface sfpr_stream_if #(parameter type payload_t = logic [7:0]);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/sfpr_ctrl.sv
module sfpr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_last,
  input  sfpr_pkg::sfpr_stat_t stat,
  output sfpr_pkg::sfpr_cmd_t  cmd
);
  import sfpr_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EVAL = 5'b00010,
    S_CRC  = 5'b00100,
    S_FIN  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t state, state_next;
  logic   streaming, streaming_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      streaming <= 1'b0;
    end else begin
      state     <= state_next;
      streaming <= streaming_next;
    end
  end

  always_comb begin
    state_next     = state;
    streaming_next = streaming;
    cmd            = '0;
    in_ready       = 1'b0;
    out_valid      = 1'b0;
    out_last       = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.crc_init = 1'b1;
        if (stat.hdr_bad || !stat.need_crc) begin
          cmd.emit_load  = 1'b1;
          streaming_next = 1'b0;
          state_next     = S_OUT;
        end else begin
          state_next = S_CRC;
        end
      end
      S_CRC: begin
        cmd.crc_step = 1'b1;
        if (stat.crc_done) state_next = S_FIN;
      end
      S_FIN: begin
        cmd.finish     = 1'b1;
        cmd.emit_load  = 1'b1;
        streaming_next = stat.stream;
        state_next     = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        out_last  = !streaming || stat.pay_last;
        if (out_ready) begin
          if (out_last) state_next = S_IDLE;
          else cmd.pay_next = 1'b1;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

FILE: rtl/sfpr_datapath.sv
module sfpr_datapath #(
  parameter int unsigned HEADER_BYTES   = 12,
  parameter int unsigned COMMAND_BYTES  = 32,
  parameter int unsigned REQUEST_BYTES  = 14,
  parameter int unsigned PAYLOAD_OFFSET = 12,
  parameter int unsigned PAYLOAD_BYTES  = 18
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [31:0] cfg_data,
  input  logic [7:0]  in_byte,
  input  sfpr_pkg::sfpr_cmd_t  cmd,
  output sfpr_pkg::sfpr_stat_t stat,
  output logic [1:0]  event_res,
  output logic [2:0]  kind,
  output logic [31:0] ts_coarse,
  output logic [15:0] ts_fine,
  output logic [7:0]  dest_addr,
  output logic        has_payload,
  output logic [7:0]  payload_byte,
  output logic [31:0] accepted_count,
  output logic [31:0] crc_error_count,
  output logic [31:0] type_error_count
);
  import sfpr_pkg::*;

  localparam int unsigned NOUT = (PAYLOAD_BYTES > MAX_OUT) ? MAX_OUT : PAYLOAD_BYTES;
  localparam int unsigned PW = $clog2(MAX_OUT + 1);

  logic [31:0] sync_word;
  logic [15:0] crc_seed;
  logic        big_endian;
  logic [7:0]  type_code [5];

  logic [7:0]  store [STORE_DEPTH];
  logic [2:0]  sync_progress;
  logic [15:0] byte_count;
  logic [15:0] expected_total;
  logic [15:0] crc;
  logic [15:0] crc_idx;
  logic [PW-1:0] pay_idx;
  logic        hdr_bad, need_crc;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_word  <= '0;
      crc_seed   <= 16'hFFFF;
      big_endian <= 1'b0;
      type_code[0] <= 8'd0; type_code[1] <= 8'd1; type_code[2] <= 8'd2;
      type_code[3] <= 8'd3; type_code[4] <= 8'd4;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_SYNC:   sync_word    <= cfg_data;
        REG_SEED:   crc_seed     <= cfg_data[15:0];
        REG_BE:     big_endian   <= cfg_data[0];
        REG_T_CMD:  type_code[0] <= cfg_data[7:0];
        REG_T_LRT:  type_code[1] <= cfg_data[7:0];
        REG_T_STOP: type_code[2] <= cfg_data[7:0];
        REG_T_LOSS: type_code[3] <= cfg_data[7:0];
        REG_T_GO:   type_code[4] <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  function automatic logic [7:0] rd(input logic [15:0] a, input logic [7:0] s [STORE_DEPTH]);
    return (a < 16'(STORE_DEPTH)) ? s[a[STORE_AW-1:0]] : 8'd0;
  endfunction

  function automatic logic [7:0] sync_at(input logic [1:0] k, input logic [31:0] w,
                                         input logic be);
    logic [1:0] j;
    j = be ? 2'd3 - k : k;
    return w[8*j +: 8];
  endfunction

  logic [2:0] kind_hdr;
  always_comb begin
    kind_hdr = KIND_UNKNOWN;
    for (int k = 4; k >= 0; k--) begin
      if (type_code[k] == store[TYPE_AT]) kind_hdr = 3'(k);
    end
  end

  logic [15:0] total_len;
  assign total_len = (kind_hdr == KIND_CMD) ? 16'(COMMAND_BYTES) : 16'(REQUEST_BYTES);

  // Byte intake
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_progress  <= '0;
      byte_count     <= '0;
      expected_total <= '0;
      hdr_bad        <= 1'b0;
      need_crc       <= 1'b0;
    end else if (cmd.take) begin
      hdr_bad  <= 1'b0;
      need_crc <= 1'b0;
      if (sync_progress < 3'd4) begin
        if (in_byte == sync_at(sync_progress[1:0], sync_word, big_endian)) begin
          store[sync_progress[1:0]] <= in_byte;
          sync_progress <= sync_progress + 3'd1;
          byte_count    <= 16'(sync_progress + 3'd1);
        end else if (in_byte == sync_at(2'd0, sync_word, big_endian)) begin
          store[0] <= in_byte;
          sync_progress <= 3'd1;
          byte_count    <= 16'd1;
        end else begin
          sync_progress <= 3'd0;
          byte_count    <= 16'd0;
        end
        expected_total <= '0;
      end else begin
        if (byte_count < 16'(STORE_DEPTH)) store[byte_count[STORE_AW-1:0]] <= in_byte;
        byte_count <= byte_count + 16'd1;
      end
    end else if (stat.in_packet && expected_total == 16'd0 &&
                 byte_count == 16'(HEADER_BYTES) && !hdr_bad && !need_crc &&
                 cmd.crc_init) begin
      // header check happens in the evaluate cycle
      if (kind_hdr == KIND_UNKNOWN) begin
        hdr_bad        <= 1'b1;
        sync_progress  <= '0;
        byte_count     <= '0;
      end else begin
        expected_total <= total_len;
        need_crc       <= byte_count >= total_len;
      end
    end else if (cmd.crc_init && expected_total != 16'd0 && stat.in_packet &&
                 byte_count >= expected_total) begin
      need_crc <= 1'b1;
    end else if (cmd.finish) begin
      sync_progress  <= '0;
      byte_count     <= '0;
      expected_total <= '0;
    end
  end

  // Evaluate cycle sees registered state; compute combinational need flags
  logic eval_hdr_bad, eval_need;
  always_comb begin
    eval_hdr_bad = 1'b0;
    eval_need    = 1'b0;
    if (stat.in_packet) begin
      if (expected_total == 16'd0 && byte_count == 16'(HEADER_BYTES)) begin
        eval_hdr_bad = (kind_hdr == KIND_UNKNOWN);
        eval_need    = !eval_hdr_bad && (byte_count >= total_len);
      end else begin
        eval_need = (expected_total != 16'd0) && (byte_count >= expected_total);
      end
    end
  end

  logic in_pkt;
  always_ff @(posedge clk) begin
    if (rst) in_pkt <= 1'b0;
    else if (cmd.take) in_pkt <= (sync_progress == 3'd4);
  end

  // CRC unit: one byte per cycle
  logic [15:0] crc_total, crc_span;
  assign crc_total = (expected_total != 16'd0) ? expected_total : total_len;
  assign crc_span  = (crc_total >= 16'(CRC_FIRST + CRC_LEN)) ?
                     crc_total - 16'(CRC_FIRST + CRC_LEN) : 16'd0;

  always_ff @(posedge clk) begin
    if (cmd.crc_init) begin
      crc     <= crc_seed;
      crc_idx <= '0;
    end else if (cmd.crc_step && crc_idx < crc_span) begin
      crc     <= crc_byte(crc, rd(16'(CRC_FIRST) + crc_idx, store));
      crc_idx <= crc_idx + 16'd1;
    end
  end

  logic [15:0] stored_crc, st_at;
  logic [7:0]  sa, sb;
  assign st_at = (crc_total >= 16'(CRC_LEN)) ? crc_total - 16'(CRC_LEN) : 16'd0;
  assign sa = rd(st_at, store);
  assign sb = rd(st_at + 16'd1, store);
  assign stored_crc = big_endian ? {sa, sb} : {sb, sa};
  logic crc_ok;
  assign crc_ok = (stored_crc == crc);

  // Totals and result fields
  logic [15:0] h0, h1, fine;
  assign h0   = big_endian ? {store[4], store[5]} : {store[5], store[4]};
  assign h1   = big_endian ? {store[6], store[7]} : {store[7], store[6]};
  assign fine = big_endian ? {store[8], store[9]} : {store[9], store[8]};

  always_ff @(posedge clk) begin
    if (rst) begin
      accepted_count   <= '0;
      crc_error_count  <= '0;
      type_error_count <= '0;
    end else if (cmd.emit_load) begin
      if (cmd.finish) begin
        if (crc_ok) accepted_count <= accepted_count + 32'd1;
        else crc_error_count <= crc_error_count + 32'd1;
      end else if (eval_hdr_bad) begin
        type_error_count <= type_error_count + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      event_res   <= EV_NONE;
      kind        <= KIND_CMD;
      ts_coarse   <= '0;
      ts_fine     <= '0;
      dest_addr   <= '0;
      has_payload <= 1'b0;
      pay_idx     <= '0;
      if (cmd.finish) begin
        if (crc_ok) begin
          event_res   <= EV_ACC;
          kind        <= (kind_hdr == KIND_UNKNOWN) ? KIND_CMD : kind_hdr;
          ts_coarse   <= big_endian ? {h0, h1} : {h1, h0};
          ts_fine     <= fine;
          dest_addr   <= store[TARGET_AT];
          has_payload <= (kind_hdr == KIND_CMD);
        end else begin
          event_res <= EV_CRC;
        end
      end else if (eval_hdr_bad) begin
        event_res <= EV_TYPE;
      end
    end else if (cmd.pay_next) begin
      pay_idx <= pay_idx + PW'(1);
    end
  end

  assign payload_byte = has_payload ? rd(16'(PAYLOAD_OFFSET) + 16'(pay_idx), store) : 8'd0;

  assign stat.in_packet = in_pkt;
  assign stat.hdr_bad   = eval_hdr_bad;
  assign stat.need_crc  = eval_need;
  assign stat.crc_done  = (crc_idx >= crc_span);
  assign stat.stream    = crc_ok && (kind_hdr == KIND_CMD);
  assign stat.pay_last  = (pay_idx == PW'(NOUT - 1));
endmodule

FILE: rtl/sync_framed_packet_receiver.sv
// A byte that completes nothing goes from evaluate to the result state for its status.
// A byte that completes a packet also passes the serial CRC walk and the finish state.
// No byte is taken until the prior status is taken; the serial CRC unit sets the
// packet-end cost; an accepted command streams one payload per cycle unless stalled.
// Reset (rst, synchronous): config to defaults, hunt restarts, totals cleared.
module sync_framed_packet_receiver #(
  parameter int unsigned HEADER_BYTES   = 12,
  parameter int unsigned COMMAND_BYTES  = 32,
  parameter int unsigned REQUEST_BYTES  = 14,
  parameter int unsigned PAYLOAD_OFFSET = 12,
  parameter int unsigned PAYLOAD_BYTES  = 18
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [31:0] cfg_data,
  sfpr_stream_if.sink   in_ch,
  sfpr_stream_if.source out_ch
);
  import sfpr_pkg::*;

  sfpr_cmd_t  cmd;
  sfpr_stat_t stat;
  logic       last;

  // Controller sequences take / evaluate / CRC / finish / result transfer
  sfpr_ctrl u_ctrl (
    .clk, .rst,
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .out_last (last),
    .stat, .cmd
  );

  // Datapath holds store, sync matcher, CRC and totals
  sfpr_datapath #(
    .HEADER_BYTES(HEADER_BYTES), .COMMAND_BYTES(COMMAND_BYTES),
    .REQUEST_BYTES(REQUEST_BYTES), .PAYLOAD_OFFSET(PAYLOAD_OFFSET),
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_dp (
    .clk, .rst, .cfg_we, .cfg_idx, .cfg_data,
    .in_byte         (in_ch.data),
    .cmd, .stat,
    .event_res       (out_ch.data.event_res),
    .kind            (out_ch.data.kind),
    .ts_coarse       (out_ch.data.ts_coarse),
    .ts_fine         (out_ch.data.ts_fine),
    .dest_addr       (out_ch.data.dest_addr),
    .has_payload     (out_ch.data.has_payload),
    .payload_byte    (out_ch.data.payload_byte),
    .accepted_count  (out_ch.data.accepted_count),
    .crc_error_count (out_ch.data.crc_error_count),
    .type_error_count(out_ch.data.type_error_count)
  );

  assign out_ch.data.last = last;
endmodule

FILE: rtl/sfpr_checker.sv
module sfpr_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_last
);
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken during result");
  a_in_then_out: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready) else $error("two bytes without result");
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && out_last) |=> !out_valid) else $error("result after last");
endmodule

bind sync_framed_packet_receiver sfpr_checker u_chk (
  .clk, .rst,
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_last(out_ch.data.last)
);

FILE: tb/sync_framed_packet_receiver_tb.sv
module sync_framed_packet_receiver_tb;
  import sfpr_pkg::*;

  // Default build of the block; the tb packet builder uses these lengths too.
  localparam int unsigned HDR_LEN  = 12;
  localparam int unsigned CMD_LEN  = 32;
  localparam int unsigned REQ_LEN  = 14;
  localparam int unsigned PAY_OFS  = 12;
  localparam int unsigned PAY_LEN  = 18;
  localparam int unsigned MAX_CYC  = 400000;

  // One status transfer out of the block.
  typedef sfpr_result_t rx_status_t;

  // Shadow receiver: mirrors hunt/buffer/CRC state and queues expected status.
  class rx_scoreboard;
    logic [31:0] sync_word;
    logic [15:0] seed;
    logic        be;
    logic [7:0]  type_code[5];
    logic [7:0]  pkt[STORE_DEPTH];
    int unsigned hunt_pos, byte_cnt, want_len;
    logic [31:0] n_acc, n_crc, n_type;
    rx_status_t  status_q[$];
    bit          failed;

    function new();
      sync_word = '0; seed = 16'hFFFF; be = 1'b0;
      for (int i = 0; i < 5; i++) type_code[i] = i[7:0];
      for (int i = 0; i < STORE_DEPTH; i++) pkt[i] = '0;
      hunt_pos = 0; byte_cnt = 0; want_len = 0;
      n_acc = '0; n_crc = '0; n_type = '0;
      failed = 1'b0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_SYNC:   sync_word = val;
        REG_SEED:   seed = val[15:0];
        REG_BE:     be = val[0];
        REG_T_CMD:  type_code[0] = val[7:0];
        REG_T_LRT:  type_code[1] = val[7:0];
        REG_T_STOP: type_code[2] = val[7:0];
        REG_T_LOSS: type_code[3] = val[7:0];
        REG_T_GO:   type_code[4] = val[7:0];
        default:    ;
      endcase
    endfunction

    function logic [7:0] sync_byte(int unsigned k);
      return be ? sync_word[(3 - k) * 8 +: 8] : sync_word[k * 8 +: 8];
    endfunction

    // First matching code wins; KIND_UNKNOWN when none match.
    function logic [2:0] kind_of(logic [7:0] t);
      for (int k = 0; k < 5; k++) if (type_code[k] == t) return k[2:0];
      return KIND_UNKNOWN;
    endfunction

    function logic [15:0] crc16(logic [7:0] data[$]);
      logic [15:0] c;
      c = seed;
      foreach (data[i]) begin
        c ^= {data[i], 8'h00};
        for (int b = 0; b < 8; b++) c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
      end
      return c;
    endfunction

    function logic [7:0] rd(int unsigned at);
      return (at < STORE_DEPTH) ? pkt[at] : 8'h00;
    endfunction

    function logic [15:0] field16(int unsigned at);
      return be ? {rd(at), rd(at + 1)} : {rd(at + 1), rd(at)};
    endfunction

    function void rehunt();
      byte_cnt = 0; want_len = 0; hunt_pos = 0;
    endfunction

    // One transferred input byte: advance the shadow and queue its status.
    function void note_byte(logic [7:0] b);
      rx_status_t r;
      logic [7:0] span[$];
      logic [2:0] kd;
      int unsigned n;
      bit streaming;
      r = '0; n = 1; streaming = 0;
      if (hunt_pos < 4) begin
        if (b == sync_byte(hunt_pos)) begin
          pkt[hunt_pos] = b; hunt_pos++;
        end else if (b == sync_byte(0)) begin
          pkt[0] = b; hunt_pos = 1;
        end else begin
          hunt_pos = 0;
        end
        byte_cnt = hunt_pos; want_len = 0;
      end else begin
        if (byte_cnt < STORE_DEPTH) pkt[byte_cnt] = b;
        byte_cnt = (byte_cnt + 1) & 16'hFFFF;
        if (want_len == 0 && byte_cnt == HDR_LEN) begin
          kd = kind_of(rd(TYPE_AT));
          if (kd == KIND_UNKNOWN) begin
            n_type++; rehunt(); r.event_res = EV_TYPE;
          end else begin
            want_len = (kd == KIND_CMD) ? CMD_LEN : REQ_LEN;
          end
        end
        if (r.event_res == EV_NONE && want_len != 0 && byte_cnt >= want_len) begin
          for (int i = CRC_FIRST; i < want_len - CRC_LEN; i++) span.push_back(rd(i));
          if (field16(want_len - CRC_LEN) == crc16(span)) begin
            r.event_res = EV_ACC;
            kd = kind_of(rd(TYPE_AT));
            r.kind = (kd == KIND_UNKNOWN) ? KIND_CMD : kd;
            r.ts_coarse = be ? {field16(4), field16(6)} : {field16(6), field16(4)};
            r.ts_fine = field16(8);
            r.dest_addr = rd(TARGET_AT);
            n_acc++;
            if (r.kind == KIND_CMD && PAY_LEN > 0) begin
              streaming = 1;
              n = (PAY_LEN > MAX_OUT) ? MAX_OUT : PAY_LEN;
            end
          end else begin
            r.event_res = EV_CRC; n_crc++;
          end
          rehunt();
        end
      end
      r.accepted_count = n_acc;
      r.crc_error_count = n_crc;
      r.type_error_count = n_type;
      for (int k = 0; k < n; k++) begin
        r.has_payload = streaming;
        r.payload_byte = streaming ? rd(PAY_OFS + k) : 8'h00;
        r.last = (k + 1 == n);
        status_q.push_back(r);
      end
    endfunction

    function void check_status(rx_status_t got);
      rx_status_t w;
      if (status_q.size() == 0) begin
        $error("unexpected status transfer %h", got);
        failed = 1;
        return;
      end
      w = status_q.pop_front();
      if (got.event_res !== w.event_res) begin
        $error("event_res exp %0d got %0d", w.event_res, got.event_res); failed = 1;
      end
      if (got.kind !== w.kind) begin
        $error("kind exp %0d got %0d", w.kind, got.kind); failed = 1;
      end
      if (got.ts_coarse !== w.ts_coarse) begin
        $error("ts_coarse exp %h got %h", w.ts_coarse, got.ts_coarse); failed = 1;
      end
      if (got.ts_fine !== w.ts_fine) begin
        $error("ts_fine exp %h got %h", w.ts_fine, got.ts_fine); failed = 1;
      end
      if (got.dest_addr !== w.dest_addr) begin
        $error("dest_addr exp %h got %h", w.dest_addr, got.dest_addr); failed = 1;
      end
      if (got.has_payload !== w.has_payload) begin
        $error("has_payload exp %b got %b", w.has_payload, got.has_payload); failed = 1;
      end
      if (got.payload_byte !== w.payload_byte) begin
        $error("payload_byte exp %h got %h", w.payload_byte, got.payload_byte); failed = 1;
      end
      if (got.last !== w.last) begin
        $error("last exp %b got %b", w.last, got.last); failed = 1;
      end
      if (got.accepted_count !== w.accepted_count) begin
        $error("accepted_count exp %0d got %0d", w.accepted_count, got.accepted_count);
        failed = 1;
      end
      if (got.crc_error_count !== w.crc_error_count) begin
        $error("crc_error_count exp %0d got %0d", w.crc_error_count, got.crc_error_count);
        failed = 1;
      end
      if (got.type_error_count !== w.type_error_count) begin
        $error("type_error_count exp %0d got %0d", w.type_error_count, got.type_error_count);
        failed = 1;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_idx = '0;
  logic [31:0] cfg_data = '0;

  sfpr_stream_if #(.payload_t(logic [7:0])) in_if ();
  sfpr_stream_if #(.payload_t(rx_status_t)) out_if ();

  sync_framed_packet_receiver #(
    .HEADER_BYTES(HDR_LEN), .COMMAND_BYTES(CMD_LEN), .REQUEST_BYTES(REQ_LEN),
    .PAYLOAD_OFFSET(PAY_OFS), .PAYLOAD_BYTES(PAY_LEN)
  ) dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .in_ch(in_if.sink), .out_ch(out_if.source)
  );

  rx_scoreboard sb = new();
  int unsigned  cycles = 0;
  int unsigned  burst_left = 0;
  int unsigned  stall_mode = 0;
  int unsigned  n_sent = 0;

  always #10 clk = ~clk;

  initial begin
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
  end

  // Watchdog: well above the slowest legal run for this stimulus.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYC) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Status sink: the stall mode is redrawn at random; mode 0 never stalls,
  // mode 1 is a fixed two-of-three pattern, mode 2 is a coin flip.
  always @(negedge clk) begin
    if (cycles % 64 == 0) stall_mode <= $urandom_range(2);
    case (stall_mode)
      0:       out_if.ready <= 1'b1;
      1:       out_if.ready <= (cycles % 3 != 0);
      default: out_if.ready <= 1'($urandom_range(1));
    endcase
  end

  // Every status transfer is checked against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_if.valid && out_if.ready) sb.check_status(out_if.data);
  end

  // Register writes go back to back on falling edges; block must be idle.
  task automatic write_regs(logic [31:0] vals[8]);
    for (int i = 0; i < 8; i++) begin
      @(negedge clk);
      cfg_we <= 1'b1;
      cfg_idx <= i[2:0];
      cfg_data <= vals[i];
      sb.set_reg(i[2:0], vals[i]);
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Sender works in bursts; valid drops only across a nonzero gap between
  // bursts, so it is never lowered and raised in the same step.
  // Called at a falling edge.
  task automatic send_byte(logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(6);
      if (gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(3) == 0) ? 40 : $urandom_range(1, 8);
    end
    in_if.valid <= 1'b1;
    in_if.data <= b;
    do @(posedge clk); while (!in_if.ready);
    sb.note_byte(b);
    n_sent++;
    burst_left--;
    @(negedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    in_if.valid <= 1'b0;
    burst_left = 0;
    while (sb.status_q.size() != 0) @(negedge clk);
    // room for any packet-end CRC walk still in flight
    repeat (2 * CMD_LEN + 8) @(negedge clk);
  endtask

  // Sync header plus body: time fields, type, target, payload, CRC trailer.
  // cut > 0 truncates the packet; bad_crc flips one trailer bit.
  task automatic send_packet(logic [7:0] t, bit bad_crc, int unsigned cut);
    logic [7:0] p[$];
    logic [7:0] span[$];
    logic [15:0] crc;
    int unsigned len;
    len = (sb.kind_of(t) == KIND_CMD) ? CMD_LEN : REQ_LEN;
    for (int k = 0; k < 4; k++) p.push_back(sb.sync_byte(k));
    for (int k = 0; k < 6; k++) p.push_back(8'($urandom_range(255)));
    p.push_back(t);
    p.push_back(8'($urandom_range(255)));
    while (p.size() < len - CRC_LEN) p.push_back(8'($urandom_range(255)));
    for (int i = CRC_FIRST; i < len - CRC_LEN; i++) span.push_back(p[i]);
    crc = sb.crc16(span);
    if (bad_crc) crc ^= 16'h1 << $urandom_range(15);
    if (sb.be) begin
      p.push_back(crc[15:8]); p.push_back(crc[7:0]);
    end else begin
      p.push_back(crc[7:0]); p.push_back(crc[15:8]);
    end
    if (cut != 0 && cut < p.size()) p = p[0:cut - 1];
    foreach (p[i]) send_byte(p[i]);
  endtask

  function automatic logic [7:0] unknown_type();
    logic [7:0] t;
    do t = 8'($urandom_range(255)); while (sb.kind_of(t) != KIND_UNKNOWN);
    return t;
  endfunction

  // Mostly well-formed packets with random content, plus noise and breakage.
  task automatic random_traffic(int unsigned n_bytes);
    int unsigned start;
    start = n_sent;
    while (n_sent - start < n_bytes) begin
      case ($urandom_range(9))
        0: repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(255)));
        1: send_packet(sb.type_code[$urandom_range(4)], 0, $urandom_range(1, 13));
        2: send_packet(sb.type_code[$urandom_range(4)], 1, 0);
        3: send_packet(unknown_type(), 0, HDR_LEN);
        default: send_packet(sb.type_code[$urandom_range(4)], 0, 0);
      endcase
    end
  endtask

  initial begin
    logic [31:0] regs[8];
    logic [7:0] s0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Phase 1: distinct codes, little-endian, directed cases first.
    regs = '{32'hA5C396E1, 32'h1D0F, 32'h0, 32'h10, 32'h11, 32'h12, 32'h13, 32'h14};
    write_regs(regs);
    // a stray first-sync byte mid-hunt restarts the match at one
    s0 = sb.sync_byte(0);
    send_byte(s0); send_byte(sb.sync_byte(1)); send_byte(s0);
    send_packet(unknown_type(), 0, HDR_LEN);
    send_packet(sb.type_code[1], 1, 0);
    for (int k = 1; k < 5; k++) send_packet(sb.type_code[k], 0, 0);
    // hold off until every status is back, then resume
    in_if.valid <= 1'b0;
    burst_left = 0;
    while (sb.status_q.size() != 0) @(negedge clk);
    random_traffic(8);
    drain();

    // Phase 2: all-ones sync, zero seed, big-endian, extreme codes.
    regs = '{32'hFFFFFFFF, 32'h0, 32'h1, 32'hFF, 32'h00, 32'h80, 32'h7F, 32'h01};
    write_regs(regs);
    send_packet(sb.type_code[0], 0, 0);
    random_traffic(8);
    drain();

    // Phase 3: all-zero sync, duplicate codes resolve to the first match.
    regs = '{32'h0, 32'hFFFF, 32'h0, 32'h33, 32'h33, 32'h44, 32'h44, 32'h55};
    write_regs(regs);
    send_packet(8'h33, 0, 0);
    drain();

    // Phase 4: random sync, seed and codes, big-endian.
    regs[0] = $urandom();
    regs[1] = $urandom_range(16'hFFFF);
    regs[2] = 32'h1;
    for (int i = 3; i < 8; i++) regs[i] = $urandom_range(255);
    write_regs(regs);
    random_traffic(8);
    drain();

    if (!sb.failed) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
